// ===== src/dpss_pkg.sv =====
package dpss_pkg;

  localparam int unsigned PwmWidthDefault = 16;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PERIOD_FIXED   = 3'd0,
    CFG_PERIOD_CURRENT = 3'd1,
    CFG_PAUSE_TICKS    = 3'd2,
    CFG_MIN_DUTY_TICKS = 3'd3,
    CFG_NORMAL_RATE    = 3'd4,
    CFG_HIGH_RATE      = 3'd5,
    CFG_LOW_RATE       = 3'd6,
    CFG_LIMIT_RATE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic              converter_on;
    logic              charge_mode;
    logic              trickle_active;
    logic signed [15:0] bus_volt_adc;
    logic signed [15:0] bus_volt_filtered;
    logic signed [15:0] bat_volt_filtered;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [15:0] low_cmp_a;
    logic [15:0] low_cmp_b;
    logic [15:0] high_cmp_a;
    logic [15:0] high_cmp_b;
    logic        low_pwm_enable;
    logic        low_force_release;
    logic        high_pwm_enable;
    logic        high_force_release;
    logic        request_work;
  } out_word_t;

  typedef struct packed {
    logic [15:0] period_fixed;
    logic [15:0] period_current;
    logic [15:0] pause_ticks;
    logic [15:0] min_duty_ticks;
    logic [15:0] normal_duty_rate;
    logic [15:0] high_duty_rate;
    logic [15:0] low_duty_rate;
    logic [15:0] limit_ramp_rate;
  } cfg_t;

  typedef struct packed {
    logic [15:0] period_now;
    logic [15:0] normal_duty;
    logic [15:0] high_duty;
    logic [15:0] low_duty;
    logic [15:0] high_limit;
    logic [15:0] low_limit;
    logic [15:0] normal_pause_left;
    logic [15:0] min_duty_left;
    logic [15:0] high_pause_left;
    logic [15:0] low_pause_left;
    logic [15:0] normal_step_count;
    logic [15:0] high_step_count;
    logic [15:0] low_step_count;
    logic [15:0] high_limit_count;
    logic [15:0] low_limit_count;
    logic [14:0] finish_count;
    logic        high_ramp_done;
    logic [3:0]  enable_bits;
  } seq_state_t;

  localparam logic [15:0] HighLimitReset = 16'd100;
  localparam logic [15:0] LowLimitReset  = 16'd50;

  function automatic seq_state_t reload_state(seq_state_t s, cfg_t c);
    seq_state_t r;
    r = s;
    r.period_now        = c.period_fixed;
    r.normal_duty       = '0;
    r.high_duty         = '0;
    r.low_duty          = '0;
    r.high_limit        = HighLimitReset;
    r.low_limit         = LowLimitReset;
    r.normal_pause_left = c.pause_ticks;
    r.high_pause_left   = c.pause_ticks;
    r.low_pause_left    = c.pause_ticks;
    r.min_duty_left     = c.min_duty_ticks;
    r.normal_step_count = '0;
    r.high_step_count   = '0;
    r.low_step_count    = '0;
    r.high_limit_count  = '0;
    r.low_limit_count   = '0;
    r.finish_count      = '0;
    r.high_ramp_done    = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/dpss_cfg_regs.sv =====
module dpss_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [15:0]                cfg_data_i,
  output dpss_pkg::cfg_t             cfg_o
);
  import dpss_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_fixed     <= 16'd1000;
      cfg_q.period_current   <= 16'd1000;
      cfg_q.pause_ticks      <= 16'd500;
      cfg_q.min_duty_ticks   <= 16'd30000;
      cfg_q.normal_duty_rate <= 16'd100;
      cfg_q.high_duty_rate   <= 16'd1000;
      cfg_q.low_duty_rate    <= 16'd1000;
      cfg_q.limit_ramp_rate  <= 16'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD_FIXED:   cfg_q.period_fixed     <= cfg_data_i;
        CFG_PERIOD_CURRENT: cfg_q.period_current   <= cfg_data_i;
        CFG_PAUSE_TICKS:    cfg_q.pause_ticks      <= cfg_data_i;
        CFG_MIN_DUTY_TICKS: cfg_q.min_duty_ticks   <= cfg_data_i;
        CFG_NORMAL_RATE:    cfg_q.normal_duty_rate <= cfg_data_i;
        CFG_HIGH_RATE:      cfg_q.high_duty_rate   <= cfg_data_i;
        CFG_LOW_RATE:       cfg_q.low_duty_rate    <= cfg_data_i;
        CFG_LIMIT_RATE:     cfg_q.limit_ramp_rate  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dpss_step.sv =====
module dpss_step #(
  parameter int unsigned PWM_WIDTH = dpss_pkg::PwmWidthDefault
) (
  input  dpss_pkg::cfg_t     cfg_i,
  input  dpss_pkg::seq_state_t st_i,
  input  dpss_pkg::in_word_t in_i,
  output dpss_pkg::seq_state_t st_o,
  output dpss_pkg::out_word_t  out_o
);
  import dpss_pkg::*;

  localparam logic [3:0] EnLowPwm  = 4'b0001;
  localparam logic [3:0] EnLowRel  = 4'b0010;
  localparam logic [3:0] EnHighPwm = 4'b0100;
  localparam logic [3:0] EnHighRel = 4'b1000;
  localparam logic [15:0] PwmMask  = 16'((17'd1 << PWM_WIDTH) - 17'd1);

  seq_state_t s;
  logic [15:0] half;
  logic [15:0] cnt;
  logic signed [20:0] bus5;
  logic signed [20:0] bat31;
  logic req;
  logic [15:0] p;

  assign bus5  = 21'(in_i.bus_volt_filtered) * 21'sd5;
  assign bat31 = 21'(in_i.bat_volt_filtered) * 21'sd31;

  always_comb begin
    s    = st_i;
    req  = 1'b0;
    half = '0;
    cnt  = '0;
    if (!in_i.converter_on) begin
      s.enable_bits = s.enable_bits & ~(EnLowRel | EnHighRel);
      s = reload_state(s, cfg_i);
    end else if (in_i.charge_mode) begin
      if (s.high_pause_left != '0) begin
        s.high_pause_left = s.high_pause_left - 16'd1;
        s.enable_bits = s.enable_bits & ~(EnLowRel | EnHighRel);
        s.high_duty = 16'd57;
        s.period_now = cfg_i.period_current;
      end else if (s.high_duty < s.high_limit) begin
        cnt = s.high_step_count + 16'd1;
        if (cnt >= cfg_i.high_duty_rate) begin
          s.high_step_count = '0;
          s.high_duty = s.high_duty + 16'd1;
        end else begin
          s.high_step_count = cnt;
        end
        s.enable_bits = s.enable_bits | EnHighPwm | EnHighRel;
      end else begin
        s.high_duty = s.high_limit;
        s.enable_bits = s.enable_bits | EnHighPwm | EnHighRel;
      end
      if (!in_i.trickle_active && s.high_duty > 16'd80) begin
        half = {1'b0, s.period_now[15:1]};
        if (s.high_limit < half) begin
          cnt = s.high_limit_count + 16'd1;
          if (cnt >= cfg_i.limit_ramp_rate) begin
            s.high_limit_count = '0;
            s.high_limit = s.high_limit + 16'd1;
          end else begin
            s.high_limit_count = cnt;
          end
        end else begin
          s.high_limit = half;
          s.finish_count = s.finish_count + 15'd1;
          if (s.finish_count > 15'd30000) begin
            s.finish_count = '0;
            s.high_ramp_done = 1'b1;
          end
        end
        if (s.high_ramp_done) begin
          if (s.low_pause_left != '0) begin
            s.low_pause_left = s.low_pause_left - 16'd1;
            s.low_duty = '0;
            s.period_now = cfg_i.period_current;
          end else if (s.low_duty < s.low_limit) begin
            cnt = s.low_step_count + 16'd1;
            if (cnt >= cfg_i.low_duty_rate) begin
              s.low_step_count = '0;
              s.low_duty = s.low_duty + 16'd1;
            end else begin
              s.low_step_count = cnt;
            end
            s.enable_bits = s.enable_bits | EnLowPwm | EnLowRel;
          end else begin
            s.low_duty = s.low_limit;
            s.enable_bits = s.enable_bits | EnLowPwm | EnLowRel;
          end
          half = {1'b0, s.period_now[15:1]};
          if (s.low_limit < half) begin
            cnt = s.low_limit_count + 16'd1;
            if (cnt >= cfg_i.limit_ramp_rate) begin
              s.low_limit_count = '0;
              s.low_limit = s.low_limit + 16'd1;
            end else begin
              s.low_limit_count = cnt;
            end
          end else begin
            s.low_limit = half;
          end
        end
      end else begin
        s.high_ramp_done = 1'b0;
        s.enable_bits = (s.enable_bits & ~EnLowRel) | EnHighPwm | EnHighRel;
      end
      if (s.low_limit > s.high_limit) s.low_limit = s.high_limit;
      half = {1'b0, s.period_now[15:1]};
      if (s.high_limit > half) s.high_limit = half;
      if (s.high_duty > s.high_limit) s.high_duty = s.high_limit;
      if (s.low_limit > half) s.low_limit = half;
      if (s.low_duty > s.low_limit) s.low_duty = s.low_limit;
      req = (in_i.bus_volt_adc >= 16'sd3000) && (s.high_duty > 16'd40);
    end else begin
      if (s.normal_pause_left != '0) begin
        s.normal_pause_left = s.normal_pause_left - 16'd1;
        s.enable_bits = s.enable_bits & ~(EnLowRel | EnHighRel);
        s.normal_duty = 16'd45;
        s.period_now = cfg_i.period_current;
      end else if (s.min_duty_left != '0) begin
        s.min_duty_left = s.min_duty_left - 16'd1;
        s.enable_bits = s.enable_bits | EnLowPwm | EnLowRel;
      end else if (s.normal_duty < {1'b0, cfg_i.period_current[15:1]} && bus5 < bat31) begin
        cnt = s.normal_step_count + 16'd1;
        if (cnt >= cfg_i.normal_duty_rate) begin
          s.normal_step_count = '0;
          s.normal_duty = s.normal_duty + 16'd1;
        end else begin
          s.normal_step_count = cnt;
        end
      end else begin
        s.enable_bits = s.enable_bits | EnHighPwm | EnHighRel;
        s.normal_duty = {1'b0, s.period_now[15:1]};
      end
      s.period_now = cfg_i.period_fixed;
      s.low_duty = s.normal_duty;
      s.high_duty = s.normal_duty;
      req = (in_i.bus_volt_adc >= 16'sd3500) && (s.normal_duty > 16'd300);
    end
    if (in_i.converter_on) begin
      if (s.low_duty < 16'd25) s.low_duty = 16'd25;
      if (s.high_duty < 16'd52) s.high_duty = 16'd52;
    end
  end

  assign p = in_i.converter_on ? s.period_now : cfg_i.period_fixed;

  always_comb begin
    out_o.pwm_period = p & PwmMask;
    if (in_i.converter_on) begin
      out_o.low_cmp_a  = (p - s.low_duty + 16'd23) & PwmMask;
      out_o.low_cmp_b  = (s.low_duty - 16'd23) & PwmMask;
      out_o.high_cmp_a = (p - s.high_duty + 16'd50) & PwmMask;
      out_o.high_cmp_b = (s.high_duty - 16'd50) & PwmMask;
    end else begin
      out_o.low_cmp_a  = p & PwmMask;
      out_o.low_cmp_b  = '0;
      out_o.high_cmp_a = p & PwmMask;
      out_o.high_cmp_b = '0;
    end
    out_o.low_pwm_enable     = s.enable_bits[0];
    out_o.low_force_release  = s.enable_bits[1];
    out_o.high_pwm_enable    = s.enable_bits[2];
    out_o.high_force_release = s.enable_bits[3];
    out_o.request_work       = req;
  end

  assign st_o = s;

endmodule

// ===== src/dcdc_pwm_soft_start_sequencer.sv =====
// Each accepted word's result is computed combinationally and registered into the output register or the skid slot.
// Throughput: one word per cycle while the input is not stalled; state is updated in one pass of the step logic.
// Output register plus one skid slot: while the output is stalled one more word
// is taken, then the input stalls until the output drains.
// Reset: asynchronous, active low; configuration registers return to defaults, sequence
// state reloads, enable bits clear and no result word is pending.
module dcdc_pwm_soft_start_sequencer #(
  parameter int unsigned PWM_WIDTH = dpss_pkg::PwmWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dpss_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpss_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import dpss_pkg::*;

  cfg_t       cfg;
  seq_state_t st_q, st_d, st_rst;
  out_word_t  res;
  out_word_t  out_q, skid_q;
  logic       out_vld_q, skid_vld_q;
  logic       in_acc, out_acc;

  dpss_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  dpss_step #(.PWM_WIDTH(PWM_WIDTH)) u_step (
    .cfg_i (cfg),
    .st_i  (st_q),
    .in_i  (in_data_i),
    .st_o  (st_d),
    .out_o (res)
  );

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_acc    = out_vld_q && !out_stall_i;

  always_comb begin
    st_rst = '0;
    st_rst.period_now        = 16'd1000;
    st_rst.high_limit        = HighLimitReset;
    st_rst.low_limit         = LowLimitReset;
    st_rst.normal_pause_left = 16'd500;
    st_rst.high_pause_left   = 16'd500;
    st_rst.low_pause_left    = 16'd500;
    st_rst.min_duty_left     = 16'd30000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= st_rst;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (!out_vld_q || out_acc) begin
        if (skid_vld_q) begin
          out_q      <= skid_q;
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_q     <= res;
          out_vld_q <= in_acc;
        end
      end else if (in_acc) begin
        skid_q     <= res;
        skid_vld_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word without output word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.converter_on) |=> (!st_q.enable_bits[1] && !st_q.enable_bits[3]))
    else $error("force release kept while converter off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_vld_q)
    else $error("accepted word produced no result");

endmodule
